// ----- rtl/core/sha256e_pkg.sv -----
`default_nettype none

package sha256e_pkg;

  localparam int unsigned WordW = 32;

  // Word slots inside a 16-word block.
  localparam logic [3:0] BLOCK_LAST_POS = 4'd15;
  localparam logic [3:0] LEN_HI_POS     = 4'd14;

  localparam logic [WordW-1:0] PAD_MARKER = 32'h8000_0000;

  localparam logic [WordW-1:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Sequencer to round unit.
  typedef struct packed {
    logic             load;
    logic             start;
    logic             init_hash;
    logic [WordW-1:0] word;
  } sha256e_ctrl_t;

  // Round unit to sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } sha256e_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/sha256e_in_if.sv -----
`default_nettype none

interface sha256e_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, output data_word, output valid_bytes, output last_word,
                  input ready);
  modport sink (input valid, input data_word, input valid_bytes, input last_word,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sha256e_out_if.sv -----
`default_nettype none

interface sha256e_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;

  modport source (output valid, output digest_word, output digest_index, output digest_last,
                  input ready);
  modport sink (input valid, input digest_word, input digest_index, input digest_last,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sha256_hash_engine_unit.sv -----
`default_nettype none

// SHA-256 engine. Message words arrive on msg_i, first byte in bits 31..24, and the word
// flagged last_word may carry 0 to 4 valid bytes. Words are accepted in the idle state; when
// one completes a 16-word block the single round unit compresses it at one round per cycle,
// and the engine drops ready for the 64 rounds and a final add. After the last word the
// sequencer writes the padding and the 64-bit bit length one word per cycle, pausing while
// a filled block is compressed; the padding takes one or two further blocks, and the engine
// then presents the eight digest words on dig_o, index 0 first, digest_last on the eighth.
// The engine then returns to its initial hash state for the next message.
module sha256_hash_engine_unit
  import sha256e_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  sha256e_in_if.sink    msg_i,
  sha256e_out_if.source dig_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_MARK = 3'd2;
  localparam logic [2:0] S_ZERO = 3'd3;
  localparam logic [2:0] S_LENL = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [2:0]  ret_q, ret_d;
  logic [3:0]  pos_q, pos_d;
  logic [63:0] bits_q, bits_d;
  logic [2:0]  idx_q, idx_d;

  sha256e_ctrl_t ctrl;
  sha256e_stat_t stat;
  logic [WordW-1:0] rd_word;

  logic             push;
  logic [WordW-1:0] push_word;
  logic [2:0]       after;
  logic [2:0]       nbytes;
  logic [WordW-1:0] tail_word;

  // Last word with fewer than four bytes: keep the valid bytes and put the marker behind them.
  always_comb begin
    nbytes = (msg_i.valid_bytes > 3'd4) ? 3'd4 : msg_i.valid_bytes;
    case (nbytes)
      3'd1:    tail_word = {msg_i.data_word[31:24], 8'h80, 16'h0000};
      3'd2:    tail_word = {msg_i.data_word[31:16], 8'h80, 8'h00};
      3'd3:    tail_word = {msg_i.data_word[31:8], 8'h80};
      default: tail_word = PAD_MARKER;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    pos_d       = pos_q;
    bits_d      = bits_q;
    idx_d       = idx_q;
    push        = 1'b0;
    push_word   = '0;
    after       = state_q;
    ctrl        = '0;
    msg_i.ready = 1'b0;
    dig_o.valid = 1'b0;

    case (state_q)
      S_IDLE: begin
        msg_i.ready = 1'b1;
        if (msg_i.valid) begin
          push = 1'b1;
          if (!msg_i.last_word) begin
            push_word = msg_i.data_word;
            bits_d    = bits_q + 64'd32;
            after     = S_IDLE;
          end else begin
            bits_d = bits_q + {58'd0, nbytes, 3'b000};
            if (nbytes == 3'd4) begin
              push_word = msg_i.data_word;
              after     = S_MARK;
            end else begin
              push_word = tail_word;
              after     = S_ZERO;
            end
          end
        end
      end
      S_MARK: begin
        push      = 1'b1;
        push_word = PAD_MARKER;
        after     = S_ZERO;
      end
      S_ZERO: begin
        push = 1'b1;
        if (pos_q == LEN_HI_POS) begin
          push_word = bits_q[63:32];
          after     = S_LENL;
        end else begin
          push_word = '0;
          after     = S_ZERO;
        end
      end
      S_LENL: begin
        push      = 1'b1;
        push_word = bits_q[31:0];
        after     = S_OUT;
      end
      S_COMP: begin
        if (stat.done) state_d = ret_q;
      end
      S_OUT: begin
        dig_o.valid = 1'b1;
        if (dig_o.ready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            ctrl.init_hash = 1'b1;
            bits_d         = '0;
            pos_d          = '0;
            state_d        = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Every pushed word goes to the window; the sixteenth of a block starts compression.
    if (push) begin
      ctrl.load = 1'b1;
      ctrl.word = push_word;
      pos_d     = pos_q + 4'd1;
      if (pos_q == BLOCK_LAST_POS) begin
        ctrl.start = 1'b1;
        state_d    = S_COMP;
        ret_d      = after;
      end else begin
        state_d = after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      pos_q   <= '0;
      bits_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pos_q   <= pos_d;
      bits_q  <= bits_d;
      idx_q   <= idx_d;
    end
  end

  sha256e_round u_round (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .rd_idx_i  (idx_q),
    .rd_word_o (rd_word)
  );

  assign dig_o.digest_word  = rd_word;
  assign dig_o.digest_index = idx_q;
  assign dig_o.digest_last  = (idx_q == 3'd7);

  a_comp_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_COMP && state_q != S_IDLE |-> !stat.busy)
    else $error("sequencer left the compression wait while the round unit was busy");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_i.ready |-> state_q == S_IDLE)
    else $error("request accepted outside the idle state");

  a_digest_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_o.valid && !dig_o.ready |=>
      dig_o.valid && $stable(dig_o.digest_index) && $stable(dig_o.digest_word))
    else $error("digest word changed while waiting for ready");

endmodule

`default_nettype wire

// ----- rtl/core/sha256e_round.sv -----
`default_nettype none

module sha256e_round
  import sha256e_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sha256e_ctrl_t ctrl_i,
  output sha256e_stat_t      stat_o,
  input  wire logic [2:0]    rd_idx_i,
  output logic [WordW-1:0]   rd_word_o
);

  function automatic logic [WordW-1:0] big_sig0(input logic [WordW-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WordW-1:0] big_sig1(input logic [WordW-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WordW-1:0] sml_sig0(input logic [WordW-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WordW-1:0] sml_sig1(input logic [WordW-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  logic [WordW-1:0] chain_q [8];
  logic [WordW-1:0] wv_q    [8];
  logic [WordW-1:0] win_q   [16];
  logic [5:0]       round_q;
  logic             busy_q;
  logic             fin_q;

  logic [WordW-1:0] ch, maj, t1, t2, next_w;

  // During compression the window holds W[t] .. W[t+15]; slot 0 feeds the current round.
  always_comb begin
    ch     = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
    maj    = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
    t1     = wv_q[7] + big_sig1(wv_q[4]) + ch + ROUND_K[round_q] + win_q[0];
    t2     = big_sig0(wv_q[0]) + maj;
    next_w = sml_sig1(win_q[14]) + win_q[9] + sml_sig0(win_q[1]) + win_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      fin_q   <= 1'b0;
      round_q <= '0;
      for (int i = 0; i < 8; i++) chain_q[i] <= INIT_HASH[i];
    end else begin
      fin_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q  <= 1'b1;
        round_q <= '0;
      end else if (busy_q) begin
        round_q <= round_q + 6'd1;
        if (round_q == 6'd63) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (ctrl_i.init_hash) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= INIT_HASH[i];
      end else if (fin_q) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + wv_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load || busy_q) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= busy_q ? next_w : ctrl_i.word;
    end
    if (ctrl_i.start) begin
      for (int i = 0; i < 8; i++) wv_q[i] <= chain_q[i];
    end else if (busy_q) begin
      wv_q[7] <= wv_q[6];
      wv_q[6] <= wv_q[5];
      wv_q[5] <= wv_q[4];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[3] <= wv_q[2];
      wv_q[2] <= wv_q[1];
      wv_q[1] <= wv_q[0];
      wv_q[0] <= t1 + t2;
    end
  end

  assign stat_o.busy = busy_q || fin_q;
  assign stat_o.done = fin_q;
  assign rd_word_o   = chain_q[rd_idx_i];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_q && !fin_q)
    else $error("compression started while the round unit is busy");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load |-> !busy_q && !fin_q)
    else $error("schedule window loaded during compression");

  a_fin_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && round_q == 6'd63 && !ctrl_i.start |=> fin_q && !busy_q)
    else $error("final add did not follow the last round");

  a_fin_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> !fin_q)
    else $error("final add lasted more than one cycle");

endmodule

`default_nettype wire
